// ===== rtl/core/qkv_pkg.sv =====
`timescale 1ns / 1ps

package qkv_pkg;

    localparam int DATA_W   = 16;
    localparam int FEATURES = 5;
    localparam int NPROJ    = 3;
    localparam int PROJ_W   = 2;

    localparam logic [PROJ_W-1:0] PROJ_KEY   = 2'd0;
    localparam logic [PROJ_W-1:0] PROJ_QUERY = 2'd1;
    localparam logic [PROJ_W-1:0] PROJ_VALUE = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] x0;
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] x3;
        logic signed [DATA_W-1:0] x4;
    } row_t;

    typedef struct packed {
        logic [PROJ_W-1:0]        projection;
        logic signed [DATA_W-1:0] y0;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
        logic signed [DATA_W-1:0] y3;
        logic signed [DATA_W-1:0] y4;
        logic                     last;
    } result_t;

    typedef struct packed {
        logic              s1_load;
        logic              s2_load;
        logic [PROJ_W-1:0] proj;
        logic [PROJ_W-1:0] s1_proj;
    } lane_ctl_t;

    // weights in tenths: [projection][feature][column]
    localparam int WT_TENTHS [NPROJ][FEATURES][FEATURES] = '{
        '{'{1, 2, 3, 4, 5}, '{5, 4, 3, 2, 1}, '{6, 7, 8, 9, 10},
          '{10, 9, 8, 7, 6}, '{9, 8, 7, 6, 5}},
        '{'{2, 3, 4, 5, 6}, '{6, 5, 4, 3, 2}, '{7, 8, 9, 10, 11},
          '{11, 10, 9, 8, 7}, '{10, 9, 8, 7, 6}},
        '{'{3, 4, 5, 6, 7}, '{7, 6, 5, 4, 3}, '{8, 9, 10, 11, 12},
          '{12, 11, 10, 9, 8}, '{11, 10, 9, 8, 7}}
    };

    localparam int BIAS_TENTHS [NPROJ][FEATURES] = '{
        '{1, 2, 3, 4, 5},
        '{2, 3, 4, 5, 6},
        '{3, 4, 5, 6, 7}
    };

    // tenths to fixed point, halves rounded up
    function automatic int tenths_fixed(input int tenths, input int frac_bits);
        int scaled;
        scaled = tenths << frac_bits;
        return (scaled + 5) / 10;
    endfunction

endpackage

// ===== rtl/core/qkv_linear_projection_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// row       in   row_valid / row_ready        qkv_pkg::row_t    (x0..x4)
// result    out  result_valid / result_ready  qkv_pkg::result_t (projection, y0..y4, last)
//
// Each row yields key, query and value results in that order, one per cycle unless result_ready stalls them.
// The five column lanes share their multipliers across the three projections.
// The first result passes the row register, the product stage, the partial-sum stage and the output register.
// Reset clears all valid flags and the projection selects; the data registers are not reset.
// A stalled result holds the pipeline; the next row is taken while results drain.

module qkv_linear_projection_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             row_valid,
    output logic             row_ready,
    input  qkv_pkg::row_t    row,
    output logic             result_valid,
    input  logic             result_ready,
    output qkv_pkg::result_t result
);
    import qkv_pkg::*;

    row_t              row_reg;
    logic              row_valid_reg;
    logic [PROJ_W-1:0] proj_reg;
    logic              s1_valid_reg;
    logic [PROJ_W-1:0] s1_proj_reg;
    logic              s2_valid_reg;
    logic [PROJ_W-1:0] s2_proj_reg;
    logic              out_load;
    logic              s2_load;
    logic              s1_load;
    lane_ctl_t         ctl;
    logic signed [DATA_W-1:0] y [FEATURES];

    assign out_load  = s2_valid_reg && (!result_valid || result_ready);
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || out_load);
    assign s1_load   = row_valid_reg && (!s1_valid_reg || s2_load);
    assign row_ready = !row_valid_reg || (s1_load && (proj_reg == PROJ_VALUE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
            proj_reg      <= PROJ_KEY;
            s1_valid_reg  <= 1'b0;
            s1_proj_reg   <= PROJ_KEY;
            s2_valid_reg  <= 1'b0;
            s2_proj_reg   <= PROJ_KEY;
        end
        else
        begin
            if (row_valid && row_ready)
            begin
                row_valid_reg <= 1'b1;
                proj_reg      <= PROJ_KEY;
            end
            else if (s1_load)
            begin
                if (proj_reg == PROJ_VALUE)
                begin
                    row_valid_reg <= 1'b0;
                end
                else
                begin
                    proj_reg <= proj_reg + 2'd1;
                end
            end

            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
                s1_proj_reg  <= proj_reg;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
                s2_proj_reg  <= s1_proj_reg;
            end
            else if (out_load)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_valid && row_ready)
        begin
            row_reg <= row;
        end
    end

    assign ctl.s1_load = s1_load;
    assign ctl.s2_load = s2_load;
    assign ctl.proj    = proj_reg;
    assign ctl.s1_proj = s1_proj_reg;

    for (genvar gj = 0; gj < FEATURES; gj++) begin : g_lane
        qkv_lane #(
            .FRAC_BITS (FRAC_BITS),
            .COL       (gj)
        ) u_lane (
            .clk (clk),
            .row (row_reg),
            .ctl (ctl),
            .y   (y[gj])
        );
    end

    qkv_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .y            (y),
        .proj         (s2_proj_reg),
        .load         (out_load),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/core/qkv_lane.sv =====
`timescale 1ns / 1ps

module qkv_lane #(
    parameter int FRAC_BITS = 12,
    parameter int COL       = 0
) (
    input  logic                              clk,
    input  qkv_pkg::row_t                     row,
    input  qkv_pkg::lane_ctl_t                ctl,
    output logic signed [qkv_pkg::DATA_W-1:0] y
);
    import qkv_pkg::*;

    localparam int W_W    = FRAC_BITS + 2;
    localparam int PROD_W = DATA_W + W_W;
    localparam int PSUM_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 3;
    localparam int RND_W  = ACC_W + 1;
    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);

    logic signed [W_W-1:0]    w_tab [NPROJ][FEATURES];
    logic signed [ACC_W-1:0]  b_tab [NPROJ];
    logic signed [DATA_W-1:0] xv    [FEATURES];
    logic signed [PROD_W-1:0] mul   [FEATURES];
    logic signed [PROD_W-1:0] prod_reg [FEATURES];
    logic signed [PSUM_W-1:0] p01_reg;
    logic signed [PSUM_W-1:0] p23_reg;
    logic signed [ACC_W-1:0]  p4b_reg;
    logic signed [ACC_W-1:0]  total;
    logic signed [RND_W-1:0]  rnd;
    logic signed [RND_W-1:0]  sh;

    for (genvar gp = 0; gp < NPROJ; gp++) begin : g_proj
        assign b_tab[gp] = ACC_W'(tenths_fixed(BIAS_TENTHS[gp][COL], FRAC_BITS)
                                  * (1 << FRAC_BITS));
        for (genvar gk = 0; gk < FEATURES; gk++) begin : g_feat
            assign w_tab[gp][gk] = W_W'(tenths_fixed(WT_TENTHS[gp][gk][COL], FRAC_BITS));
        end
    end

    assign xv[0] = row.x0;
    assign xv[1] = row.x1;
    assign xv[2] = row.x2;
    assign xv[3] = row.x3;
    assign xv[4] = row.x4;

    for (genvar gk = 0; gk < FEATURES; gk++) begin : g_mul
        assign mul[gk] = xv[gk] * w_tab[ctl.proj][gk];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            for (int k = 0; k < FEATURES; k++)
            begin
                prod_reg[k] <= mul[k];
            end
        end
        if (ctl.s2_load)
        begin
            p01_reg <= PSUM_W'(prod_reg[0]) + PSUM_W'(prod_reg[1]);
            p23_reg <= PSUM_W'(prod_reg[2]) + PSUM_W'(prod_reg[3]);
            p4b_reg <= ACC_W'(prod_reg[4]) + b_tab[ctl.s1_proj];
        end
    end

    always_comb
    begin
        total = ACC_W'(p01_reg) + ACC_W'(p23_reg) + p4b_reg;
        rnd   = RND_W'(total) + HALF;
        sh    = rnd >>> FRAC_BITS;
        if (!sh[RND_W-1] && (|sh[RND_W-2:DATA_W-1]))
        begin
            y = 16'sh7FFF;
        end
        else if (sh[RND_W-1] && !(&sh[RND_W-2:DATA_W-1]))
        begin
            y = -16'sh8000;
        end
        else
        begin
            y = sh[DATA_W-1:0];
        end
    end

endmodule

// ===== rtl/core/qkv_merge.sv =====
`timescale 1ns / 1ps

module qkv_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [qkv_pkg::DATA_W-1:0] y [qkv_pkg::FEATURES],
    input  logic [qkv_pkg::PROJ_W-1:0]        proj,
    input  logic                              load,
    input  logic                              result_ready,
    output logic                              result_valid,
    output qkv_pkg::result_t                  result
);
    import qkv_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.projection <= proj;
            data_reg.y0         <= y[0];
            data_reg.y1         <= y[1];
            data_reg.y2         <= y[2];
            data_reg.y3         <= y[3];
            data_reg.y4         <= y[4];
            data_reg.last       <= (proj == PROJ_VALUE);
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule
